// File: hdl/col_pkg.sv
// Shared types and constants of the circular ordered list engine.
package col_pkg;

  localparam int OP_BITS     = 3;
  localparam int VALUE_BITS  = 32;
  localparam int POS_BITS    = 4;
  localparam int COUNT_BITS  = 5;
  localparam int STATUS_BITS = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_REM_FRONT = 3'd2,
    OP_REM_BACK  = 3'd3,
    OP_DELETE    = 3'd4,
    OP_SEARCH    = 3'd5
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan;
    logic shift;
    logic finish;
  } ctl_t;

  typedef struct packed {
    op_t  op;
    logic hit;
    logic walk_done;
  } stat_t;

endpackage

// File: hdl/col_req_if.sv
// Request channel carrying one list operation per item.
interface col_req_if
  import col_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic [OP_BITS-1:0]           operation;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, operation, value, input ready);
  modport sink   (input valid, operation, value, output ready);
endinterface

// File: hdl/col_rsp_if.sv
// Response channel carrying one result per operation.
interface col_rsp_if
  import col_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] removed_value;
  logic                         found;
  logic [POS_BITS-1:0]          position;
  logic [COUNT_BITS-1:0]        element_count;
  logic [STATUS_BITS-1:0]       status;

  modport source (output valid, removed_value, found, position, element_count, status,
                  input ready);
  modport sink   (input valid, removed_value, found, position, element_count, status,
                  output ready);
endinterface

// File: hdl/col_datapath.sv
// Datapath of the list engine: ring storage, pointers, walk counter and result registers.
module col_datapath
  import col_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ctl_t                          ctl,
  output stat_t                         stat,
  input  logic [OP_BITS-1:0]            operation,
  input  logic signed [VALUE_BITS-1:0]  value,
  output logic signed [VALUE_BITS-1:0]  removed_value,
  output logic                          found,
  output logic [POS_BITS-1:0]           position,
  output logic [COUNT_BITS-1:0]         element_count,
  output logic [STATUS_BITS-1:0]        status
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [IW-1:0] LAST_C = IW'(CAPACITY - 1);

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];

  op_t                    op_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [VALUE_WIDTH-1:0] rd_data;
  logic [IW-1:0]          front;
  logic [CW-1:0]          count;
  logic [CW-1:0]          idx;
  logic [CW-1:0]          rd_off;
  logic [CW-1:0]          pos;
  logic                   rd_valid;
  logic                   fail;
  logic                   hit_seen;

  logic                   is_ins;
  logic                   is_rem;
  logic                   full;
  logic                   empty;
  logic                   hit;
  logic                   issue;
  logic                   rd_en;
  logic                   wr_en;
  logic [IW-1:0]          rd_addr;
  logic [IW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic [IW-1:0]          front_dec;
  logic [CW-1:0]          count_fin;
  status_t                status_fin;

  function automatic logic [IW-1:0] slot(input logic [IW-1:0] base, input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(CAPACITY)) begin
      sum = sum - SW'(CAPACITY);
    end
    return sum[IW-1:0];
  endfunction

  always_comb begin
    is_ins    = (op_q == OP_INS_FRONT) || (op_q == OP_INS_BACK);
    is_rem    = (op_q == OP_REM_FRONT) || (op_q == OP_REM_BACK);
    full      = (count == CAP_C);
    empty     = (count == '0);
    hit       = ctl.scan && rd_valid && (rd_data == val_q);
    issue     = (ctl.scan && (idx < count) && !hit) || (ctl.shift && (idx < count));
    front_dec = (front == '0) ? LAST_C : front - IW'(1);

    rd_en = (ctl.exec && is_rem && !empty) || issue;
    if (ctl.scan || ctl.shift) begin
      rd_addr = slot(front, idx);
    end else if (op_q == OP_REM_FRONT) begin
      rd_addr = front;
    end else begin
      rd_addr = slot(front, count - CW'(1));
    end

    wr_en = (ctl.exec && is_ins && !full) || (ctl.shift && rd_valid);
    if (ctl.shift) begin
      wr_addr = slot(front, rd_off - CW'(1));
      wr_data = rd_data;
    end else if (op_q == OP_INS_FRONT) begin
      wr_addr = front_dec;
      wr_data = val_q;
    end else begin
      wr_addr = slot(front, count);
      wr_data = val_q;
    end

    count_fin = count;
    if ((is_rem && !fail) || ((op_q == OP_DELETE) && hit_seen)) begin
      count_fin = count - CW'(1);
    end

    if (is_ins && fail) begin
      status_fin = ST_FULL;
    end else if (is_rem && fail) begin
      status_fin = ST_EMPTY;
    end else if (((op_q == OP_DELETE) || (op_q == OP_SEARCH)) && !hit_seen) begin
      status_fin = ST_NOT_FOUND;
    end else begin
      status_fin = ST_OK;
    end

    stat.op        = op_q;
    stat.hit       = hit;
    stat.walk_done = !rd_valid && (idx == count);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_q  <= op_t'(operation);
      val_q <= VALUE_WIDTH'(value);
    end
    if (ctl.finish) begin
      removed_value <= (is_rem && !fail) ? VALUE_BITS'($signed(rd_data)) : '0;
      found         <= hit_seen;
      position      <= hit_seen ? POS_BITS'(pos) : '0;
      element_count <= COUNT_BITS'(count_fin);
      status        <= status_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front    <= '0;
      count    <= '0;
      idx      <= '0;
      rd_off   <= '0;
      pos      <= '0;
      rd_valid <= 1'b0;
      fail     <= 1'b0;
      hit_seen <= 1'b0;
    end else begin
      if (ctl.load) begin
        idx      <= '0;
        pos      <= '0;
        rd_valid <= 1'b0;
        fail     <= 1'b0;
        hit_seen <= 1'b0;
      end
      if (ctl.exec) begin
        fail <= (is_ins && full) || (is_rem && empty);
        if (is_ins && !full) begin
          count <= count + CW'(1);
          if (op_q == OP_INS_FRONT) begin
            front <= front_dec;
          end
        end
      end
      if (ctl.scan || ctl.shift) begin
        rd_valid <= issue;
        if (issue) begin
          rd_off <= idx;
          idx    <= idx + CW'(1);
        end
      end
      if (hit) begin
        hit_seen <= 1'b1;
        pos      <= rd_off;
        idx      <= rd_off + CW'(1);
      end
      if (ctl.finish) begin
        count <= count_fin;
        if ((op_q == OP_REM_FRONT) && !fail) begin
          front <= slot(front, CW'(1));
        end
      end
    end
  end

endmodule

// File: hdl/col_controller.sv
// Controller of the list engine: sequences each operation and owns the handshakes.
module col_controller
  import col_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output ctl_t  ctl,
  input  stat_t stat
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        if ((stat.op == OP_DELETE) || (stat.op == OP_SEARCH)) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (stat.hit) begin
          state_next = (stat.op == OP_DELETE) ? S_SHIFT : S_FINISH;
        end else if (stat.walk_done) begin
          state_next = S_FINISH;
        end
      end
      S_SHIFT: begin
        ctl.shift = 1'b1;
        if (stat.walk_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    out_valid_next = ctl.finish || (out_valid && !out_ready);
  end

endmodule

// File: hdl/circular_ordered_list_engine_unit.sv
// Top level of the circular ordered list engine.
//
//   Channel   | Dir | Payload
//   ----------+-----+--------------------------------------------------------
//   request   | in  | operation, value
//   response  | out | removed_value, found, position, element_count, status
//
// Inserts, removals and unused codes pass from acceptance through an execute step to a registered result;
// search then reads entries in order up to a match or the end of the list before its result.
// Delete then moves the entries after the match toward the front, one slot each.
// The walk is set by the single read port of the ring storage, one entry per cycle.
// Reset empties the list at once; storage holds no reset value.
// A new item is accepted while the previous result waits for the response side.
module circular_ordered_list_engine_unit
  import col_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input logic        clk,
  input logic        rst,
  col_req_if.sink    request,
  col_rsp_if.source  response
);

  ctl_t  ctl;
  stat_t stat;

  col_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .out_valid (response.valid),
    .out_ready (response.ready),
    .ctl       (ctl),
    .stat      (stat)
  );

  col_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .operation     (request.operation),
    .value         (request.value),
    .removed_value (response.removed_value),
    .found         (response.found),
    .position      (response.position),
    .element_count (response.element_count),
    .status        (response.status)
  );

endmodule

// File: verif/tb_circular_ordered_list_engine_unit.sv
// Self-checking testbench of the circular ordered list engine with randomized traffic.
module tb_circular_ordered_list_engine_unit;
  import col_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 64;
  localparam int RANDOM_OPS  = 850;
  localparam int MAX_REPORTS = 10;

  // Operation codes outside the defined set; the block must leave the list alone.
  localparam logic [OP_BITS-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_BITS-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [OP_BITS-1:0]    code;
    logic [VALUE_BITS-1:0] operand;
  } list_op_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] removed_value;
    logic                  found;
    logic [POS_BITS-1:0]   position;
    logic [COUNT_BITS-1:0] element_count;
    status_t               status;
  } list_result_t;

  logic clk = 1'b0;
  logic rst;

  col_req_if request_ch ();
  col_rsp_if response_ch ();

  circular_ordered_list_engine_unit #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .request  (request_ch),
    .response (response_ch)
  );

  always #4 clk = ~clk;

  list_op_t     pending_ops[$];
  list_result_t results_due[$];
  int           mismatches     = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  int           cycle_count    = 0;

  logic [VALUE_BITS-1:0] ring [CAPACITY];
  int                    ring_front = 0;
  int                    ring_count = 0;

  logic [VALUE_BITS-1:0] common_values [8] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h0000_002A
  };

  function automatic int ring_slot(input int offset);
    return (ring_front + offset) % CAPACITY;
  endfunction

  function automatic list_result_t apply_list_op(input logic [OP_BITS-1:0] code,
                                                 input logic [VALUE_BITS-1:0] operand);
    list_result_t res;
    int           i;
    int           hit;
    res = '0;
    res.status = ST_OK;
    case (code)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (ring_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (code == OP_INS_FRONT) begin
          ring_front = (ring_front + CAPACITY - 1) % CAPACITY;
          ring[ring_front] = operand;
          ring_count++;
        end else begin
          ring[ring_slot(ring_count)] = operand;
          ring_count++;
        end
      end
      OP_REM_FRONT, OP_REM_BACK: begin
        if (ring_count == 0) begin
          res.status = ST_EMPTY;
        end else if (code == OP_REM_FRONT) begin
          res.removed_value = ring[ring_front];
          ring_front = ring_slot(1);
          ring_count--;
        end else begin
          res.removed_value = ring[ring_slot(ring_count - 1)];
          ring_count--;
        end
      end
      OP_DELETE, OP_SEARCH: begin
        hit = -1;
        for (i = 0; i < ring_count && hit < 0; i++) begin
          if (ring[ring_slot(i)] == operand) hit = i;
        end
        if (hit < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.found = 1'b1;
          res.position = hit[POS_BITS-1:0];
          if (code == OP_DELETE) begin
            for (i = hit; i + 1 < ring_count; i++) ring[ring_slot(i)] = ring[ring_slot(i + 1)];
            ring_count--;
          end
        end
      end
      default: begin
      end
    endcase
    res.element_count = ring_count[COUNT_BITS-1:0];
    return res;
  endfunction

  task automatic check_field(input string field, input logic [VALUE_BITS-1:0] want,
                             input logic [VALUE_BITS-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("Mismatch on %s: expected %0h, got %0h.", field, want, got);
    end
  endtask

  task automatic push_op(input logic [OP_BITS-1:0] code, input logic [VALUE_BITS-1:0] operand);
    list_op_t item;
    item.code = code;
    item.operand = operand;
    pending_ops.push_back(item);
  endtask

  task automatic queue_random_ops(input int n);
    int                    issued;
    int                    lean;
    int                    pick;
    int                    ins_pct;
    int                    rem_pct;
    logic [OP_BITS-1:0]    code;
    logic [VALUE_BITS-1:0] operand;
    issued = 0;
    lean = 0;
    while (issued < n) begin
      if (issued % 40 == 0) lean = $urandom_range(2);
      case (lean)
        0: begin
          ins_pct = 75;
          rem_pct = 10;
        end
        1: begin
          ins_pct = 10;
          rem_pct = 75;
        end
        default: begin
          ins_pct = 35;
          rem_pct = 30;
        end
      endcase
      pick = $urandom_range(99);
      if (pick < 3)
        code = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
      else if (pick < 3 + ins_pct)
        code = $urandom_range(1) ? OP_INS_BACK : OP_INS_FRONT;
      else if (pick < 3 + ins_pct + rem_pct)
        code = $urandom_range(1) ? OP_REM_BACK : OP_REM_FRONT;
      else
        code = $urandom_range(1) ? OP_SEARCH : OP_DELETE;
      operand = ($urandom_range(9) < 6) ? common_values[$urandom_range(7)] : $urandom();
      push_op(code, operand);
      if (code != OP_SPARE_LO && code != OP_SPARE_HI) issued++;
    end
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || results_due.size() != 0 || request_ch.valid)
      @(posedge clk);
  endtask

  always @(posedge clk) begin : drive
    list_op_t item;
    if (rst) begin
      request_ch.valid <= 1'b0;
    end else begin
      if (request_ch.valid && request_ch.ready)
        results_due.push_back(apply_list_op(request_ch.operation, request_ch.value));
      if (!request_ch.valid || request_ch.ready) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item = pending_ops.pop_front();
          request_ch.valid     <= 1'b1;
          request_ch.operation <= item.code;
          request_ch.value     <= item.operand;
        end else begin
          request_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch
    list_result_t want;
    if (rst) begin
      response_ch.ready <= 1'b0;
    end else begin
      if (response_ch.valid && response_ch.ready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) $display("Result arrived with no item pending.");
        end else begin
          want = results_due.pop_front();
          check_field("removed_value", want.removed_value, response_ch.removed_value);
          check_field("found", VALUE_BITS'(want.found), VALUE_BITS'(response_ch.found));
          check_field("position", VALUE_BITS'(want.position),
                      VALUE_BITS'(response_ch.position));
          check_field("element_count", VALUE_BITS'(want.element_count),
                      VALUE_BITS'(response_ch.element_count));
          check_field("status", VALUE_BITS'(want.status), VALUE_BITS'(response_ch.status));
        end
      end
      response_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int i;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    push_op(OP_SEARCH, 32'h0000_0007);
    push_op(OP_DELETE, 32'h0000_0007);
    push_op(OP_REM_FRONT, $urandom());
    push_op(OP_REM_BACK, $urandom());
    push_op(OP_INS_FRONT, 32'h7FFF_FFFF);
    push_op(OP_INS_BACK, 32'h8000_0000);
    push_op(OP_INS_FRONT, 32'hFFFF_FFFF);
    push_op(OP_INS_BACK, 32'h0000_0000);
    for (i = 0; i < CAPACITY - 5; i++) push_op(OP_INS_BACK, $urandom());
    push_op(OP_INS_BACK, 32'h1357_9BDF);
    push_op(OP_INS_FRONT, 32'h0000_0005);
    push_op(OP_SEARCH, 32'h1357_9BDF);
    push_op(OP_SEARCH, 32'h8000_0000);
    push_op(OP_DELETE, 32'h7FFF_FFFF);
    push_op(OP_REM_FRONT, $urandom());
    push_op(OP_REM_BACK, $urandom());
    push_op(OP_SPARE_LO, $urandom());
    push_op(OP_SPARE_HI, $urandom());
    queue_random_ops(RANDOM_OPS / 4);
    wait_drained();

    send_idle_pct = 88;
    recv_stall_pct = 0;
    queue_random_ops(RANDOM_OPS / 4);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 88;
    queue_random_ops(RANDOM_OPS / 4);
    wait_drained();

    send_idle_pct = 11;
    recv_stall_pct = 11;
    queue_random_ops(RANDOM_OPS / 4);
    wait_drained();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
